// ----- design/kcac_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad code alarm controller package
// Shared types and constants: command codes, register indexes, the register
// bundle, the sensor trip flags and the status word.
// ----------------------------------------------------------------------------
package kcac_pkg;

	// Width of the configuration data word (widest register).
	localparam int CfgDataW = 23;

	// Event kinds carried by the cmd field.
	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_ACCEL = 2'd1,
		CMD_ECHO  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_ADMIN_CODE   = 2'd0,
		REG_MOTION_LIMIT = 2'd1,
		REG_NEAR_LIMIT   = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	// Key that discards the current entry outside admin mode.
	localparam logic [3:0] KEY_CLEAR = 4'd10;

	// Reset values of the registers and of the user code.
	localparam logic [15:0] ADMIN_CODE_RST   = 16'h4321;
	localparam logic [12:0] MOTION_LIMIT_RST = 13'd5324;
	localparam logic [22:0] NEAR_LIMIT_RST   = 23'd24326;
	localparam logic [15:0] USER_CODE_RST    = 16'h1234;

	// Configuration register bundle.
	typedef struct packed {
		logic [15:0] admin_code;
		logic [12:0] motion_limit;
		logic [22:0] near_limit;
	} cfg_regs_t;

	// Sensor compare results for the word in the input register.
	typedef struct packed {
		logic motion;
		logic near;
	} trip_t;

	// Status reported with every result word.
	typedef struct packed {
		logic       armed;
		logic       alarm;
		logic       admin_active;
		logic       ready_lamp;
		logic [2:0] keys_entered;
	} status_t;

endpackage

// ----- design/keypad_code_alarm_controller_unit.sv -----
// Path: an accepted word is held in the input register, then in the result
// register, which drives the result channel.
// Throughput: one word per cycle while out_stall is low; a stall holds the words.
// Reset: arst_n clears both stages, arms the system and restores the user
// code and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Keypad code alarm controller
// Input register, lock controller with sensor compares, and result register.
// ----------------------------------------------------------------------------
module keypad_code_alarm_controller_unit #(
	parameter int CODE_LENGTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [kcac_pkg::CfgDataW-1:0] cfg_data,
	// Event channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [3:0]                    key_code,
	input  logic signed [13:0]            accel_x,
	input  logic signed [13:0]            accel_y,
	input  logic signed [13:0]            accel_z,
	input  logic [15:0]                   echo_ticks,
	input  logic [2:0]                    prescale_shift,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          armed,
	output logic                          alarm,
	output logic                          admin_active,
	output logic                          ready_lamp,
	output logic [2:0]                    keys_entered
);
	import kcac_pkg::*;

	logic               valid_s1;
	logic [1:0]         cmd_s1;
	logic [3:0]         key_s1;
	logic signed [13:0] accel_x_s1;
	logic signed [13:0] accel_y_s1;
	logic signed [13:0] accel_z_s1;
	logic [15:0]        echo_s1;
	logic [2:0]         shift_s1;

	logic               valid_s2;
	status_t            status_s2;

	logic               in_take;
	logic               advance;
	cfg_regs_t          regs;
	trip_t              trip;
	status_t            status_next;

	// Handshake: the input stage moves on when the result register is free
	// or is being emptied in the same cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers.
	kcac_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.regs      (regs)
	);

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1     <= cmd;
			key_s1     <= key_code;
			accel_x_s1 <= accel_x;
			accel_y_s1 <= accel_y;
			accel_z_s1 <= accel_z;
			echo_s1    <= echo_ticks;
			shift_s1   <= prescale_shift;
		end
	end

	// Sensor compares on the registered word.
	kcac_sensor_trip u_sensor_trip (
		.accel_x        (accel_x_s1),
		.accel_y        (accel_y_s1),
		.accel_z        (accel_z_s1),
		.echo_ticks     (echo_s1),
		.prescale_shift (shift_s1),
		.regs           (regs),
		.trip           (trip)
	);

	// Lock state, updated as the word moves into the result register.
	kcac_lock_ctrl #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_lock_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cmd         (cmd_s1),
		.key_code    (key_s1),
		.trip        (trip),
		.regs        (regs),
		.status_next (status_next)
	);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_next;
		end
	end

	assign out_valid    = valid_s2;
	assign armed        = status_s2.armed;
	assign alarm        = status_s2.alarm;
	assign admin_active = status_s2.admin_active;
	assign ready_lamp   = status_s2.ready_lamp;
	assign keys_entered = status_s2.keys_entered;

endmodule

// ----- design/kcac_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the admin code and the two sensor limits, written over a valid/ready
// channel that is always ready.
// ----------------------------------------------------------------------------
module kcac_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [1:0]                          cfg_index,
	input  logic [kcac_pkg::CfgDataW-1:0]       cfg_data,
	output logic                                cfg_ready,
	output kcac_pkg::cfg_regs_t                 regs
);
	import kcac_pkg::*;

	cfg_regs_t regs_q;

	// The registers take a write in any cycle.
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Register write decode; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.admin_code   <= ADMIN_CODE_RST;
			regs_q.motion_limit <= MOTION_LIMIT_RST;
			regs_q.near_limit   <= NEAR_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ADMIN_CODE:   regs_q.admin_code   <= cfg_data[15:0];
				REG_MOTION_LIMIT: regs_q.motion_limit <= cfg_data[12:0];
				REG_NEAR_LIMIT:   regs_q.near_limit   <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- design/kcac_sensor_trip.sv -----
// ----------------------------------------------------------------------------
// Sensor trip compare
// Compares the accelerometer axis magnitudes with the motion limit and the
// shifted echo width with the near limit.
// ----------------------------------------------------------------------------
module kcac_sensor_trip (
	input  logic signed [13:0]   accel_x,
	input  logic signed [13:0]   accel_y,
	input  logic signed [13:0]   accel_z,
	input  logic [15:0]          echo_ticks,
	input  logic [2:0]           prescale_shift,
	input  kcac_pkg::cfg_regs_t  regs,
	output kcac_pkg::trip_t      trip
);
	import kcac_pkg::*;

	logic [13:0] mag_x;
	logic [13:0] mag_y;
	logic [13:0] mag_z;
	logic [13:0] limit_ext;
	logic [22:0] echo_shifted;

	// Axis magnitudes; the most negative sample maps to 8192, which fits.
	assign mag_x = accel_x[13] ? 14'(-accel_x) : 14'(accel_x);
	assign mag_y = accel_y[13] ? 14'(-accel_y) : 14'(accel_y);
	assign mag_z = accel_z[13] ? 14'(-accel_z) : 14'(accel_z);
	assign limit_ext = {1'b0, regs.motion_limit};

	assign trip.motion = (mag_x > limit_ext) || (mag_y > limit_ext) || (mag_z > limit_ext);

	// A 16-bit width shifted by at most seven stays below the 23-bit top,
	// so the shift never overflows and no saturation is needed.
	assign echo_shifted = 23'(echo_ticks) << prescale_shift;

	assign trip.near = (echo_shifted != '0) && (echo_shifted < regs.near_limit);

endmodule

// ----- design/kcac_lock_ctrl.sv -----
// ----------------------------------------------------------------------------
// Code lock controller
// Holds the lock state: entry buffer, user code, admin mode, armed and alarm.
// Works out the state after one event word and updates it on a step.
// ----------------------------------------------------------------------------
module kcac_lock_ctrl #(
	parameter int CODE_LENGTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           cmd,
	input  logic [3:0]           key_code,
	input  kcac_pkg::trip_t      trip,
	input  kcac_pkg::cfg_regs_t  regs,
	output kcac_pkg::status_t    status_next
);
	import kcac_pkg::*;

	localparam int CodeW = 4 * CODE_LENGTH;
	localparam int CntW  = $clog2(CODE_LENGTH + 1);
	localparam logic [CntW-1:0] CntFull = CntW'(CODE_LENGTH);

	logic [CodeW-1:0] user_code_q, user_code_d;
	logic [CodeW-1:0] entry_keys_q, entry_keys_d;
	logic [CntW-1:0]  entry_cnt_q, entry_cnt_d;
	logic             admin_q, admin_d;
	logic [CodeW-1:0] new_keys_q, new_keys_d;
	logic [CntW-1:0]  new_cnt_q, new_cnt_d;
	logic             armed_q, armed_d;
	logic             alarm_q, alarm_d;

	logic [CodeW-1:0] admin_code_ext;
	logic [CodeW-1:0] entry_shift;
	logic [CodeW-1:0] new_shift;
	logic [CntW-1:0]  entry_inc;
	logic [CntW-1:0]  new_inc;
	logic [3:0]       cnt_ext;

	assign admin_code_ext = CodeW'(regs.admin_code);
	assign entry_shift    = CodeW'({entry_keys_q, key_code});
	assign new_shift      = CodeW'({new_keys_q, key_code});
	assign entry_inc      = CntW'(entry_cnt_q + 1'b1);
	assign new_inc        = CntW'(new_cnt_q + 1'b1);

	// Next state for one event word.
	always_comb begin
		user_code_d  = user_code_q;
		entry_keys_d = entry_keys_q;
		entry_cnt_d  = entry_cnt_q;
		admin_d      = admin_q;
		new_keys_d   = new_keys_q;
		new_cnt_d    = new_cnt_q;
		armed_d      = armed_q;
		alarm_d      = alarm_q;
		case (cmd_t'(cmd))
			CMD_KEY: begin
				if (admin_q) begin
					// Admin mode: the key goes into the new user code.
					new_keys_d = new_shift;
					new_cnt_d  = new_inc;
					if (new_inc >= CntFull) begin
						user_code_d = new_shift;
						admin_d     = 1'b0;
						new_cnt_d   = '0;
					end
				end else begin
					entry_keys_d = entry_shift;
					entry_cnt_d  = entry_inc;
					if (entry_inc >= CntFull) begin
						if (entry_shift == user_code_q) begin
							armed_d = !armed_q;
							alarm_d = 1'b0;
						end else if (entry_shift == admin_code_ext) begin
							admin_d   = 1'b1;
							armed_d   = 1'b0;
							alarm_d   = 1'b0;
							new_cnt_d = '0;
						end
						entry_cnt_d  = '0;
						entry_keys_d = '0;
					end
					// The clear key empties the entry after any check.
					if (key_code == KEY_CLEAR) begin
						entry_cnt_d  = '0;
						entry_keys_d = '0;
					end
				end
			end
			CMD_ACCEL: begin
				if (armed_q && trip.motion) begin
					alarm_d = 1'b1;
				end
			end
			CMD_ECHO: begin
				if (armed_q && trip.near) begin
					alarm_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Lock state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_code_q  <= CodeW'(USER_CODE_RST);
			entry_keys_q <= '0;
			entry_cnt_q  <= '0;
			admin_q      <= 1'b0;
			new_cnt_q    <= '0;
			armed_q      <= 1'b1;
			alarm_q      <= 1'b0;
		end else if (step) begin
			user_code_q  <= user_code_d;
			entry_keys_q <= entry_keys_d;
			entry_cnt_q  <= entry_cnt_d;
			admin_q      <= admin_d;
			new_cnt_q    <= new_cnt_d;
			armed_q      <= armed_d;
			alarm_q      <= alarm_d;
		end
	end

	// New code buffer, always filled completely before it is used.
	always_ff @(posedge clk) begin
		if (step) begin
			new_keys_q <= new_keys_d;
		end
	end

	// Status after the event.
	assign cnt_ext = 4'(entry_cnt_d);

	assign status_next.armed        = armed_d;
	assign status_next.alarm        = alarm_d;
	assign status_next.admin_active = admin_d;
	assign status_next.ready_lamp   = armed_d && !alarm_d;
	assign status_next.keys_entered = cnt_ext[2:0];

endmodule

// ----- verif/kcac_lock_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad code alarm controller status checker
// Watches the configuration, event and result channels. It tracks the lock
// state for every accepted event word and compares each result word, field
// by field, with the oldest predicted status.
// ----------------------------------------------------------------------------
module kcac_lock_check #(
	parameter int CODE_LENGTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [kcac_pkg::CfgDataW-1:0]       cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [3:0]                          key_code,
	input  logic signed [13:0]                  accel_x,
	input  logic signed [13:0]                  accel_y,
	input  logic signed [13:0]                  accel_z,
	input  logic [15:0]                         echo_ticks,
	input  logic [2:0]                          prescale_shift,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                armed,
	input  logic                                alarm,
	input  logic                                admin_active,
	input  logic                                ready_lamp,
	input  logic [2:0]                          keys_entered,
	output logic [31:0]                         mismatches,
	output logic [31:0]                         words_pending
);
	import kcac_pkg::*;

	localparam int CodeW = 4 * CODE_LENGTH;

	// Shadow copy of the registers.
	logic [15:0] admin_code_c;
	logic [12:0] motion_lim;
	logic [22:0] near_lim;

	// Shadow copy of the lock state.
	logic [CodeW-1:0] user_code;
	logic [CodeW-1:0] entry_keys;
	logic [CodeW-1:0] next_code;
	int               entry_cnt;
	int               next_cnt;
	bit               admin_on;
	bit               armed_q;
	bit               alarm_q;

	status_t status_due[$];
	status_t got;
	status_t want;
	int      errs;

	// Any axis magnitude above the limit counts as motion.
	function automatic bit axis_trips(logic signed [13:0] a);
		int v;
		v = a;
		if (v < 0)
			v = -v;
		return v > int'(motion_lim);
	endfunction

	// Shifted echo saturates at the range top; zero means no echo.
	function automatic bit echo_trips(logic [15:0] t, logic [2:0] sh);
		logic [31:0] s;
		s = {16'd0, t} << sh;
		if (s > 32'h007F_FFFF)
			s = 32'h007F_FFFF;
		return (s != 32'd0) && (s < {9'd0, near_lim});
	endfunction

	// One key press: either a digit of the new user code or of the entry.
	task automatic apply_key(logic [3:0] k);
		if (admin_on) begin
			next_code = (next_code << 4) | CodeW'(k);
			next_cnt++;
			if (next_cnt >= CODE_LENGTH) begin
				user_code = next_code;
				admin_on  = 1'b0;
				next_cnt  = 0;
			end
			return;
		end
		entry_keys = (entry_keys << 4) | CodeW'(k);
		entry_cnt++;
		if (entry_cnt >= CODE_LENGTH) begin
			if (entry_keys == user_code) begin
				armed_q = !armed_q;
				alarm_q = 1'b0;
			end else if (entry_keys == CodeW'(admin_code_c)) begin
				admin_on = 1'b1;
				armed_q  = 1'b0;
				alarm_q  = 1'b0;
				next_cnt = 0;
			end
			entry_cnt  = 0;
			entry_keys = '0;
		end
		// The clear key always empties the entry outside admin mode.
		if (k == KEY_CLEAR) begin
			entry_cnt  = 0;
			entry_keys = '0;
		end
	endtask

	// Advance the shadow state by one event word and queue the status it shows.
	task automatic predict_status();
		status_t s;
		case (cmd)
			CMD_KEY: begin
				apply_key(key_code);
			end
			CMD_ACCEL: begin
				if (armed_q && (axis_trips(accel_x) || axis_trips(accel_y) ||
						axis_trips(accel_z)))
					alarm_q = 1'b1;
			end
			CMD_ECHO: begin
				if (armed_q && echo_trips(echo_ticks, prescale_shift))
					alarm_q = 1'b1;
			end
			default: begin
			end
		endcase
		s.armed        = armed_q;
		s.alarm        = alarm_q;
		s.admin_active = admin_on;
		s.ready_lamp   = armed_q && !alarm_q;
		s.keys_entered = entry_cnt[2:0];
		status_due.push_back(s);
	endtask

	task automatic note_mismatch(string field, int exp_v, int act_v);
		if (errs < 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field,
				exp_v, act_v);
		errs++;
	endtask

	// Channel monitor: register writes, result compares, then event words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admin_code_c  = ADMIN_CODE_RST;
			motion_lim    = MOTION_LIMIT_RST;
			near_lim      = NEAR_LIMIT_RST;
			user_code     = CodeW'(USER_CODE_RST);
			entry_keys    = '0;
			next_code     = '0;
			entry_cnt     = 0;
			next_cnt      = 0;
			admin_on      = 1'b0;
			armed_q       = 1'b1;
			alarm_q       = 1'b0;
			status_due.delete();
			words_pending <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ADMIN_CODE:   admin_code_c = cfg_data[15:0];
					REG_MOTION_LIMIT: motion_lim   = cfg_data[12:0];
					REG_NEAR_LIMIT:   near_lim     = cfg_data[22:0];
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{armed, alarm, admin_active, ready_lamp, keys_entered};
				if (status_due.size() == 0) begin
					note_mismatch("unexpected result word", 0, 1);
				end else begin
					want = status_due.pop_front();
					if (got.armed !== want.armed)
						note_mismatch("armed", want.armed, got.armed);
					if (got.alarm !== want.alarm)
						note_mismatch("alarm", want.alarm, got.alarm);
					if (got.admin_active !== want.admin_active)
						note_mismatch("admin_active", want.admin_active, got.admin_active);
					if (got.ready_lamp !== want.ready_lamp)
						note_mismatch("ready_lamp", want.ready_lamp, got.ready_lamp);
					if (got.keys_entered !== want.keys_entered)
						note_mismatch("keys_entered", want.keys_entered, got.keys_entered);
				end
			end
			if (in_valid && !in_stall)
				predict_status();
			words_pending <= status_due.size();
		end
	end

	initial errs = 0;
	always @(posedge clk)
		mismatches <= errs;

endmodule

// ----- verif/keypad_code_alarm_controller_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad code alarm controller testbench
// Drives directed and random key, accelerometer and echo words through the
// controller under several register settings, with random gaps and output
// stalls. A status checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module keypad_code_alarm_controller_unit_tb;
	import kcac_pkg::*;

	localparam int CODE_LENGTH = 4;
	localparam logic [3:0] KEY_HASH = 4'd11;
	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 280;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = REG_ADMIN_CODE;
	logic [CfgDataW-1:0]   cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            cmd = CMD_KEY;
	logic [3:0]            key_code = '0;
	logic signed [13:0]    accel_x = '0;
	logic signed [13:0]    accel_y = '0;
	logic signed [13:0]    accel_z = '0;
	logic [15:0]           echo_ticks = '0;
	logic [2:0]            prescale_shift = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  armed;
	logic                  alarm;
	logic                  admin_active;
	logic                  ready_lamp;
	logic [2:0]            keys_entered;
	logic [31:0]           mismatches;
	logic [31:0]           words_pending;

	// What the stimulus believes the codes and limits are.
	logic [15:0] admin_now;
	logic [15:0] user_guess;
	logic [12:0] motion_now;
	logic [22:0] near_now;
	int          words_sent = 0;
	int          send_burst = 0;
	int          stall_burst = 0;

	always #6 clk = ~clk;

	keypad_code_alarm_controller_unit #(.CODE_LENGTH(CODE_LENGTH)) dut (.*);

	kcac_lock_check #(.CODE_LENGTH(CODE_LENGTH)) lock_check (.*);

	function automatic logic [13:0] rand14();
		return 14'($urandom_range(0, 16383));
	endfunction

	function automatic logic [2:0] rand3();
		return 3'($urandom_range(0, 7));
	endfunction

	// A code the keypad can actually enter: the clear key only as the last key.
	function automatic logic [15:0] fresh_code();
		logic [15:0] c;
		logic [3:0]  k;
		c = '0;
		for (int i = 0; i < 4; i++) begin
			k = 4'($urandom_range(0, 15));
			if (k == KEY_CLEAR && i != 3)
				k = 4'd0;
			c = {c[11:0], k};
		end
		return c;
	endfunction

	// Axis value that is close to the motion limit on either side in half the draws.
	function automatic logic [13:0] axis_value();
		int v;
		v = int'(motion_now) + $urandom_range(0, 2) - 1;
		case ($urandom_range(0, 3))
			0: return rand14();
			1: return (v > 8191) ? 14'sd8191 : 14'(v);
			2: return 14'(-v);
			default: return 14'($urandom_range(0, 64));
		endcase
	endfunction

	// Send one event word after a random gap and wait until it is taken.
	task automatic send_word(logic [1:0] c, logic [3:0] k, logic [13:0] ax,
			logic [13:0] ay, logic [13:0] az, logic [15:0] t, logic [2:0] sh);
		int gap;
		if (send_burst > 0) begin
			gap = 0;
			send_burst--;
		end else begin
			gap = $urandom_range(0, 3);
			if ($urandom_range(0, 19) == 0)
				send_burst = $urandom_range(16, 48);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd            <= c;
		key_code       <= k;
		accel_x        <= ax;
		accel_y        <= ay;
		accel_z        <= az;
		echo_ticks     <= t;
		prescale_shift <= sh;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_key(logic [3:0] k);
		send_word(CMD_KEY, k, rand14(), rand14(), rand14(), 16'($urandom), rand3());
	endtask

	task automatic send_code(logic [15:0] code);
		for (int i = 3; i >= 0; i--)
			send_key(code[4*i +: 4]);
	endtask

	task automatic send_accel(logic [13:0] ax, logic [13:0] ay, logic [13:0] az);
		send_word(CMD_ACCEL, 4'($urandom), ax, ay, az, 16'($urandom), rand3());
	endtask

	task automatic send_echo(logic [15:0] t, logic [2:0] sh);
		send_word(CMD_ECHO, 4'($urandom), rand14(), rand14(), rand14(), t, sh);
	endtask

	// Echo placed right around the near limit after shifting in half the draws.
	task automatic send_echo_near();
		logic [2:0] sh;
		int         t;
		sh = rand3();
		t  = int'(near_now >> sh) + $urandom_range(0, 2) - 1;
		case ($urandom_range(0, 3))
			0: t = $urandom_range(0, 65535);
			1: t = 0;
			default: begin
			end
		endcase
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		send_echo(16'(t), sh);
	endtask

	// Hold off new words until every result word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	task automatic put_reg(reg_idx_t idx, logic [CfgDataW-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write every register back to back, plus the unused index.
	task automatic load_config(logic [15:0] admin, logic [12:0] motion, logic [22:0] near_v);
		cfg_valid <= 1'b1;
		put_reg(REG_ADMIN_CODE, CfgDataW'(admin));
		put_reg(REG_MOTION_LIMIT, CfgDataW'(motion));
		put_reg(REG_NEAR_LIMIT, CfgDataW'(near_v));
		put_reg(REG_UNUSED, CfgDataW'($urandom));
		cfg_valid  <= 1'b0;
		admin_now  = admin;
		motion_now = motion;
		near_now   = near_v;
	endtask

	// One random sequence: mostly valid code entries and sensor words.
	task automatic random_sequence();
		int          r;
		logic [15:0] next_code;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			send_key(KEY_CLEAR);
			send_code(user_guess);
		end else if (r < 35) begin
			next_code = fresh_code();
			send_key(KEY_CLEAR);
			send_code(admin_now);
			send_code(next_code);
			user_guess = next_code;
		end else if (r < 75) begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 1) == 0)
					send_accel(axis_value(), axis_value(), axis_value());
				else
					send_echo_near();
			end
		end else if (r < 87) begin
			repeat ($urandom_range(1, 5))
				send_key(4'($urandom_range(0, 15)));
		end else if (r < 92) begin
			send_word(CMD_NONE, 4'($urandom), rand14(), rand14(), rand14(),
				16'($urandom), rand3());
		end else begin
			send_key(KEY_CLEAR);
			send_key(user_guess[15:12]);
			send_key(user_guess[11:8]);
			send_key(4'($urandom_range(0, 15)));
		end
	endtask

	// Result side: random stalls per word, with stretches of none.
	initial begin
		int n;
		forever begin
			if (stall_burst > 0) begin
				n = 0;
				stall_burst--;
			end else begin
				n = $urandom_range(0, 3);
				if ($urandom_range(0, 19) == 0)
					stall_burst = $urandom_range(16, 48);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Main stimulus.
	initial begin
		admin_now  = ADMIN_CODE_RST;
		user_guess = USER_CODE_RST;
		motion_now = MOTION_LIMIT_RST;
		near_now   = NEAR_LIMIT_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: user code disarms, sensors ignored while disarmed, rearm.
		send_code(16'h1234);
		send_accel(14'sh2000, 14'sh2000, 14'sh2000);
		send_echo(16'd1, 3'd0);
		send_code(16'h1234);
		// Limits are strict: equal magnitude, zero echo and the largest shifted echo do not trip.
		send_accel(14'sd5324, -14'sd5324, 14'sd0);
		send_echo(16'd0, 3'd7);
		send_echo(16'hFFFF, 3'd7);
		send_echo(16'd24326, 3'd0);
		send_word(CMD_NONE, 4'hF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 16'hFFFF, 3'd7);
		send_accel(14'sd8191, 14'sd0, 14'sh2000);
		// Admin code clears the alarm; the clear key is a plain key of the new code.
		send_code(ADMIN_CODE_RST);
		send_key(KEY_CLEAR);
		send_key(4'd15);
		send_key(4'd0);
		send_key(4'd9);
		user_guess = 16'hAF09;
		// Clear key mid-entry discards it; hash is an ordinary key.
		send_key(4'd2);
		send_key(KEY_CLEAR);
		send_key(KEY_HASH);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1: load_config(16'hFFFF, 13'd0, 23'h7F_FFFF);
					2: load_config(16'h0000, 13'h1FFF, 23'd0);
					default: load_config(fresh_code(), 13'($urandom_range(0, 8191)),
						($urandom_range(0, 1) == 0) ? 23'($urandom_range(0, 200000)) :
						23'($urandom));
				endcase
			end
			while (words_sent < 27 + (p + 1) * PHASE_WORDS)
				random_sequence();
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && words_pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a hung channel.
	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
